@@ rtl/core/jst_pkg.sv @@
// Shared types, codes and helper functions for the JSON scalar tokenizer.
`timescale 1ns / 1ps

package jst_pkg;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_NULL     = 3'd0,
        KIND_BOOL     = 3'd1,
        KIND_NUMBER   = 3'd2,
        KIND_STR_CHAR = 3'd3,
        KIND_STR_END  = 3'd4,
        KIND_ERROR    = 3'd5
    } kind_t;

    // Error codes
    typedef enum logic [2:0] {
        ERR_UNEXPECTED   = 3'd0,
        ERR_NULL         = 3'd1,
        ERR_BOOL         = 3'd2,
        ERR_LEAD_ZERO    = 3'd3,
        ERR_BAD_NUMBER   = 3'd4,
        ERR_NO_FRAC      = 3'd5,
        ERR_UNTERMINATED = 3'd6,
        ERR_ESCAPE       = 3'd7
    } err_t;

    // Lexer modes
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_LIT   = 3'd1,
        MODE_MINUS = 3'd2,
        MODE_ZERO  = 3'd3,
        MODE_INT   = 3'd4,
        MODE_DOT   = 3'd5,
        MODE_FRAC  = 3'd6,
        MODE_STR   = 3'd7
    } mode_t;

    // Literal selectors
    localparam logic [1:0] LIT_NULL  = 2'd0;
    localparam logic [1:0] LIT_TRUE  = 2'd1;
    localparam logic [1:0] LIT_FALSE = 2'd2;

    // Character codes
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_F         = 8'h66;

    // Saturated magnitude of the integer part
    localparam logic [31:0] SAT_MAG = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    // Output queue
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    typedef struct packed {
        kind_t              kind;
        logic               bool_value;
        logic signed [31:0] number_value;
        logic               has_fraction;
        logic [7:0]         string_char;
        err_t               error_code;
        logic               last;
    } result_t;

    // Blank result of a given kind
    function automatic result_t res_make(kind_t k);
        result_t r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    // Error result with a given code
    function automatic result_t res_error(err_t e);
        result_t r;
        r = '0;
        r.kind = KIND_ERROR;
        r.error_code = e;
        return r;
    endfunction

    // Number result from sign, saturated magnitude and fraction flag
    function automatic result_t res_number(logic neg, logic [31:0] mag, logic frac);
        result_t r;
        r = '0;
        r.kind = KIND_NUMBER;
        r.has_fraction = frac;
        if (mag[31])
            r.number_value = neg ? SAT_MAG : POS_MAX;
        else
            r.number_value = neg ? (32'd0 - mag) : mag;
        return r;
    endfunction

    // Expected character of a literal at a position
    function automatic logic [7:0] lit_char(logic [1:0] k, logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            LIT_TRUE:
            begin
                case (p)
                    3'd0: c = "t";
                    3'd1: c = "r";
                    3'd2: c = "u";
                    3'd3: c = "e";
                    default: c = 8'h00;
                endcase
            end
            LIT_FALSE:
            begin
                case (p)
                    3'd0: c = "f";
                    3'd1: c = "a";
                    3'd2: c = "l";
                    3'd3: c = "s";
                    3'd4: c = "e";
                    default: c = 8'h00;
                endcase
            end
            default:
            begin
                case (p)
                    3'd0: c = "n";
                    3'd1: c = "u";
                    3'd2: c = "l";
                    3'd3: c = "l";
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/jst_lexer.sv @@
// Lexer state and per-byte step logic; yields up to two results per byte.
`timescale 1ns / 1ps

module jst_lexer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             end_of_input,
    output logic [1:0]       push_cnt,
    output jst_pkg::result_t push0,
    output jst_pkg::result_t push1
);
    import jst_pkg::*;

    mode_t       mode_reg, mode_mid, mode_next;
    logic [1:0]  kind_reg, kind_mid, kind_next;
    logic [2:0]  pos_reg, pos_mid, pos_next;
    logic        neg_reg, neg_mid, neg_next;
    logic [31:0] acc_reg, acc_mid, acc_next;
    logic        frac_reg, frac_mid, frac_next;

    logic [1:0]  lk;
    logic [2:0]  llen;
    logic [2:0]  lpos;
    logic        is_digit;
    logic        to_idle;
    logic        do_start;
    logic        num_hit;
    logic        main_hit;
    logic        eoi_hit;
    result_t     num_res;
    result_t     main_res;
    result_t     eoi_res;
    logic [31:0] acc_digit;

    // Multiply the magnitude by ten, add the digit, saturate at 2^31
    function automatic logic [31:0] acc_step(logic [31:0] acc, logic [3:0] d);
        logic [34:0] sum;
        sum = {3'b000, acc} * 35'd10 + {31'd0, d};
        return (sum > {3'b000, SAT_MAG}) ? SAT_MAG : sum[31:0];
    endfunction

    assign is_digit  = (in_byte inside {[CH_ZERO:CH_NINE]});
    assign acc_digit = acc_step(acc_reg, in_byte[3:0]);

    // Clamp literal selector and position
    always_comb
    begin
        lk   = (kind_reg > LIT_FALSE) ? LIT_NULL : kind_reg;
        llen = (lk == LIT_FALSE) ? 3'd5 : 3'd4;
        lpos = (pos_reg < llen) ? pos_reg : 3'd0;
    end

    // Handle the byte in the current mode, then a token start if needed
    always_comb
    begin : step
        mode_mid = mode_reg;
        kind_mid = kind_reg;
        pos_mid  = pos_reg;
        neg_mid  = neg_reg;
        acc_mid  = acc_reg;
        frac_mid = frac_reg;
        to_idle  = 1'b0;
        do_start = 1'b0;
        num_hit  = 1'b0;
        main_hit = 1'b0;
        main_res = res_make(KIND_NULL);
        num_res  = res_number(neg_reg, acc_reg, frac_reg);

        case (mode_reg)
            MODE_LIT:
            begin
                if (in_byte == lit_char(lk, lpos))
                begin
                    pos_mid = lpos + 3'd1;
                    if (lpos + 3'd1 >= llen)
                    begin
                        main_hit = 1'b1;
                        if (lk == LIT_NULL)
                            main_res = res_make(KIND_NULL);
                        else
                        begin
                            main_res = res_make(KIND_BOOL);
                            main_res.bool_value = (lk == LIT_TRUE);
                        end
                        to_idle = 1'b1;
                    end
                end
                else
                begin
                    main_hit = 1'b1;
                    main_res = res_error((lk == LIT_NULL) ? ERR_NULL : ERR_BOOL);
                    to_idle  = 1'b1;
                end
            end
            MODE_MINUS:
            begin
                if (in_byte == CH_ZERO)
                    mode_mid = MODE_ZERO;
                else if (is_digit)
                begin
                    acc_mid  = acc_digit;
                    mode_mid = MODE_INT;
                end
                else
                begin
                    main_hit = 1'b1;
                    main_res = res_error(ERR_BAD_NUMBER);
                    to_idle  = 1'b1;
                end
            end
            MODE_ZERO:
            begin
                if (is_digit)
                begin
                    main_hit = 1'b1;
                    main_res = res_error(ERR_LEAD_ZERO);
                    to_idle  = 1'b1;
                end
                else if (in_byte == CH_DOT)
                    mode_mid = MODE_DOT;
                else
                begin
                    num_hit  = 1'b1;
                    do_start = 1'b1;
                end
            end
            MODE_INT:
            begin
                if (is_digit)
                    acc_mid = acc_digit;
                else if (in_byte == CH_DOT)
                    mode_mid = MODE_DOT;
                else
                begin
                    num_hit  = 1'b1;
                    do_start = 1'b1;
                end
            end
            MODE_DOT:
            begin
                if (is_digit)
                begin
                    frac_mid = 1'b1;
                    mode_mid = MODE_FRAC;
                end
                else
                begin
                    main_hit = 1'b1;
                    main_res = res_error(ERR_NO_FRAC);
                    to_idle  = 1'b1;
                end
            end
            MODE_FRAC:
            begin
                if (!is_digit)
                begin
                    num_hit  = 1'b1;
                    do_start = 1'b1;
                end
            end
            MODE_STR:
            begin
                main_hit = 1'b1;
                if (in_byte == CH_QUOTE)
                begin
                    main_res = res_make(KIND_STR_END);
                    to_idle  = 1'b1;
                end
                else if (in_byte == CH_BACKSLASH)
                begin
                    main_res = res_error(ERR_ESCAPE);
                    to_idle  = 1'b1;
                end
                else
                begin
                    main_res = res_make(KIND_STR_CHAR);
                    main_res.string_char = in_byte;
                end
            end
            default:
                do_start = 1'b1;
        endcase

        // Drop back to idle
        if (to_idle || do_start)
        begin
            mode_mid = MODE_IDLE;
            kind_mid = LIT_NULL;
            pos_mid  = 3'd0;
            neg_mid  = 1'b0;
            acc_mid  = 32'd0;
            frac_mid = 1'b0;
        end

        // Start the next token
        if (do_start)
        begin
            if (in_byte inside {CH_SPACE, CH_TAB, CH_CR, CH_LF})
                mode_mid = MODE_IDLE;
            else if (in_byte inside {CH_N, CH_T, CH_F})
            begin
                mode_mid = MODE_LIT;
                kind_mid = (in_byte == CH_N) ? LIT_NULL :
                           (in_byte == CH_T) ? LIT_TRUE : LIT_FALSE;
                pos_mid  = 3'd1;
            end
            else if (in_byte == CH_MINUS)
            begin
                neg_mid  = 1'b1;
                mode_mid = MODE_MINUS;
            end
            else if (in_byte == CH_ZERO)
                mode_mid = MODE_ZERO;
            else if (is_digit)
            begin
                acc_mid  = {28'd0, in_byte[3:0]};
                mode_mid = MODE_INT;
            end
            else if (in_byte == CH_QUOTE)
                mode_mid = MODE_STR;
            else
            begin
                main_hit = 1'b1;
                main_res = res_error(ERR_UNEXPECTED);
            end
        end
    end

    // Close any open token at end of input
    always_comb
    begin : finish
        mode_next = mode_mid;
        kind_next = kind_mid;
        pos_next  = pos_mid;
        neg_next  = neg_mid;
        acc_next  = acc_mid;
        frac_next = frac_mid;
        eoi_hit   = 1'b0;
        eoi_res   = res_make(KIND_NULL);

        if (end_of_input)
        begin
            case (mode_mid)
                MODE_LIT:
                begin
                    eoi_hit = 1'b1;
                    eoi_res = res_error((kind_mid == LIT_NULL) ? ERR_NULL : ERR_BOOL);
                end
                MODE_MINUS:
                begin
                    eoi_hit = 1'b1;
                    eoi_res = res_error(ERR_BAD_NUMBER);
                end
                MODE_ZERO, MODE_INT, MODE_FRAC:
                begin
                    eoi_hit = 1'b1;
                    eoi_res = res_number(neg_mid, acc_mid, frac_mid);
                end
                MODE_DOT:
                begin
                    eoi_hit = 1'b1;
                    eoi_res = res_error(ERR_NO_FRAC);
                end
                MODE_STR:
                begin
                    eoi_hit = 1'b1;
                    eoi_res = res_error(ERR_UNTERMINATED);
                end
                default:
                    eoi_hit = 1'b0;
            endcase
            mode_next = MODE_IDLE;
            kind_next = LIT_NULL;
            pos_next  = 3'd0;
            neg_next  = 1'b0;
            acc_next  = 32'd0;
            frac_next = 1'b0;
        end
    end

    // Order the results: number, then byte result, then end-of-input result
    always_comb
    begin : outputs
        push0 = res_make(KIND_NULL);
        push1 = res_make(KIND_NULL);
        if (num_hit)
        begin
            push0 = num_res;
            push1 = main_hit ? main_res : eoi_res;
        end
        else if (main_hit)
        begin
            push0 = main_res;
            push1 = eoi_res;
        end
        else
            push0 = eoi_res;

        push_cnt = {1'b0, num_hit} + {1'b0, main_hit} + {1'b0, eoi_hit};
        push0.last = (push_cnt == 2'd1);
        push1.last = 1'b1;
    end

    // Advance lexer state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            kind_reg <= LIT_NULL;
            pos_reg  <= 3'd0;
            neg_reg  <= 1'b0;
            acc_reg  <= 32'd0;
            frac_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            kind_reg <= kind_next;
            pos_reg  <= pos_next;
            neg_reg  <= neg_next;
            acc_reg  <= acc_next;
            frac_reg <= frac_next;
        end
    end

endmodule

@@ rtl/core/jst_outq.sv @@
// Shifting result queue that takes up to two results per cycle.
`timescale 1ns / 1ps

module jst_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_cnt,
    input  jst_pkg::result_t push0,
    input  jst_pkg::result_t push1,
    input  logic             out_stall,
    output logic             out_valid,
    output jst_pkg::result_t head,
    output logic             full
);
    import jst_pkg::*;

    logic [OUTQ_CW-1:0] count_reg, count_next;
    logic [OUTQ_CW-1:0] base;
    logic               pop;
    result_t            slot_reg  [OUTQ_DEPTH];
    result_t            slot_next [OUTQ_DEPTH];

    assign out_valid = (count_reg != '0);
    assign head      = slot_reg[0];
    assign full      = (count_reg > OUTQ_CW'(OUTQ_DEPTH - 2));
    assign pop       = out_valid && !out_stall;
    assign base      = count_reg - {{(OUTQ_CW-1){1'b0}}, pop};

    // Shift down on pop, then append new results after the survivors
    always_comb
    begin
        for (int i = 0; i < OUTQ_DEPTH; i++)
        begin
            if (pop && (i < OUTQ_DEPTH - 1))
                slot_next[i] = slot_reg[(i < OUTQ_DEPTH - 1) ? i + 1 : i];
            else
                slot_next[i] = slot_reg[i];
            if ((push_cnt != 2'd0) && (base == OUTQ_CW'(i)))
                slot_next[i] = push0;
            if ((push_cnt == 2'd2) && (base + OUTQ_CW'(1) == OUTQ_CW'(i)))
                slot_next[i] = push1;
        end
        count_next = base + {{(OUTQ_CW-2){1'b0}}, push_cnt};
    end

    // Hold queue payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < OUTQ_DEPTH; i++)
            slot_reg[i] <= slot_next[i];
    end

    // Track fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

@@ rtl/core/json_scalar_tokenizer.sv @@
// Top level of the JSON scalar tokenizer: byte lexer feeding a result queue.
//
//   Channel  Handshake                 Payload
//   -------  ------------------------  ------------------------------------------
//   item     item_valid / item_stall   in_byte, end_of_input
//   result   result_valid / result_stall  kind, bool_value, number_value,
//                                      has_fraction, string_char, error_code, last
//
// One byte is taken per cycle while item_stall is low; its results (zero, one or two)
// enter a four-entry queue when accepted and leave one per cycle if not stalled.
// Two results come from a number ended by an unexpected byte or by a token start at
// end of input, or from a byte result and the end-of-input close; a run of these can
// fill the queue, and item_stall is high while it holds three or more results.
// Reset puts the lexer in idle with an empty queue.
`timescale 1ns / 1ps

module json_scalar_tokenizer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [7:0]         in_byte,
    input  logic               end_of_input,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [2:0]         kind,
    output logic               bool_value,
    output logic signed [31:0] number_value,
    output logic               has_fraction,
    output logic [7:0]         string_char,
    output logic [2:0]         error_code,
    output logic               last
);
    import jst_pkg::*;

    logic       accept;
    logic [1:0] push_cnt;
    logic [1:0] push_cnt_q;
    result_t    push0;
    result_t    push1;
    result_t    head;
    logic       full;

    assign item_stall = full;
    assign accept     = item_valid && !item_stall;
    assign push_cnt_q = accept ? push_cnt : 2'd0;

    jst_lexer u_lexer (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .push_cnt     (push_cnt),
        .push0        (push0),
        .push1        (push1)
    );

    jst_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt_q),
        .push0     (push0),
        .push1     (push1),
        .out_stall (result_stall),
        .out_valid (result_valid),
        .head      (head),
        .full      (full)
    );

    // Drive result fields from the queue head
    assign kind         = head.kind;
    assign bool_value   = head.bool_value;
    assign number_value = head.number_value;
    assign has_fraction = head.has_fraction;
    assign string_char  = head.string_char;
    assign error_code   = head.error_code;
    assign last         = head.last;

endmodule

@@ verif/json_scalar_tokenizer_tb.sv @@
// Self-checking testbench for the JSON scalar tokenizer: byte stimulus, token prediction, checks.
`timescale 1ns / 1ps

module json_scalar_tokenizer_tb;

    import jst_pkg::*;

    // A run with nothing accepted for this long is stuck: the longest legal quiet
    // stretch is the long receiver hold (LONG_HOLD) plus a sender gap.
    localparam int STUCK_LIMIT = 5000;
    localparam int LONG_HOLD   = 200;

    typedef struct {
        logic [7:0] value;
        logic       ends_text;
    } text_byte_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    logic [7:0]         in_byte = 8'h00;
    logic               end_of_input = 1'b0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [2:0]         kind;
    logic               bool_value;
    logic signed [31:0] number_value;
    logic               has_fraction;
    logic [7:0]         string_char;
    logic [2:0]         error_code;
    logic               last;

    text_byte_t text_queue[$];
    result_t    expected_tokens[$];
    result_t    step_tokens[$];

    // Lexer state mirrored for prediction
    mode_t       lex_mode = MODE_IDLE;
    logic [1:0]  lit_sel = LIT_NULL;
    logic [2:0]  lit_pos = 3'd0;
    logic        lex_neg = 1'b0;
    logic [32:0] lex_mag = 33'd0;
    logic        lex_frac = 1'b0;

    int  error_count = 0;
    int  tokens_seen = 0;
    int  stuck_cycles = 0;
    int  queued_bytes = 0;
    int  ignored_bytes = 0;
    bit  steady = 1'b0;
    bit  timed_out = 1'b0;

    int  burst_left = 0;
    int  gap_left = 0;
    int  stall_window = 0;
    int  stall_pct = 0;
    int  long_hold_left = 0;
    bit  long_hold_done = 1'b0;

    json_scalar_tokenizer u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- prediction

    function automatic string literal_spelling(logic [1:0] sel);
        if (sel == LIT_TRUE)
            return "true";
        else if (sel == LIT_FALSE)
            return "false";
        return "null";
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    task automatic clear_lexer();
        lex_mode = MODE_IDLE;
        lit_sel  = LIT_NULL;
        lit_pos  = 3'd0;
        lex_neg  = 1'b0;
        lex_mag  = 33'd0;
        lex_frac = 1'b0;
    endtask

    task automatic note_simple(kind_t k, logic flag, logic [7:0] ch);
        result_t r;
        r = '0;
        r.kind = k;
        r.bool_value = flag;
        r.string_char = ch;
        step_tokens.push_back(r);
    endtask

    task automatic note_error(err_t e);
        result_t r;
        r = '0;
        r.kind = KIND_ERROR;
        r.error_code = e;
        step_tokens.push_back(r);
        clear_lexer();
    endtask

    // Apply sign and saturation to the magnitude, then drop back to idle
    task automatic note_number();
        result_t r;
        logic [31:0] v;
        if (lex_mag >= {1'b0, SAT_MAG})
            v = lex_neg ? SAT_MAG : POS_MAX;
        else
            v = lex_neg ? (32'd0 - lex_mag[31:0]) : lex_mag[31:0];
        r = '0;
        r.kind = KIND_NUMBER;
        r.number_value = v;
        r.has_fraction = lex_frac;
        step_tokens.push_back(r);
        clear_lexer();
    endtask

    task automatic add_digit(logic [7:0] b);
        logic [63:0] grown;
        logic [7:0]  d;
        d = b - CH_ZERO;
        grown = {31'd0, lex_mag} * 64'd10 + {56'd0, d};
        lex_mag = (grown > {32'd0, SAT_MAG}) ? {1'b0, SAT_MAG} : grown[32:0];
    endtask

    task automatic begin_token(logic [7:0] b);
        clear_lexer();
        if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF)
            return;
        if (b == CH_N || b == CH_T || b == CH_F)
        begin
            lex_mode = MODE_LIT;
            lit_sel = (b == CH_N) ? LIT_NULL : (b == CH_T) ? LIT_TRUE : LIT_FALSE;
            lit_pos = 3'd1;
        end
        else if (b == CH_MINUS)
        begin
            lex_neg = 1'b1;
            lex_mode = MODE_MINUS;
        end
        else if (b == CH_ZERO)
            lex_mode = MODE_ZERO;
        else if (is_digit(b))
        begin
            add_digit(b);
            lex_mode = MODE_INT;
        end
        else if (b == CH_QUOTE)
            lex_mode = MODE_STR;
        else
            note_error(ERR_UNEXPECTED);
    endtask

    // Work out the tokens caused by one accepted byte and queue them
    task automatic lex_byte(logic [7:0] b, logic eoi);
        string   spell;
        int      i;
        result_t r;
        step_tokens.delete();
        case (lex_mode)
            MODE_LIT:
            begin
                spell = literal_spelling(lit_sel);
                if (lit_pos >= spell.len())
                    lit_pos = 3'd0;
                if (b == spell[lit_pos])
                begin
                    lit_pos = lit_pos + 3'd1;
                    if (lit_pos >= spell.len())
                    begin
                        if (lit_sel == LIT_NULL)
                            note_simple(KIND_NULL, 1'b0, 8'h00);
                        else
                            note_simple(KIND_BOOL, lit_sel == LIT_TRUE, 8'h00);
                        clear_lexer();
                    end
                end
                else if (lit_sel == LIT_NULL)
                    note_error(ERR_NULL);
                else
                    note_error(ERR_BOOL);
            end
            MODE_MINUS:
            begin
                if (b == CH_ZERO)
                    lex_mode = MODE_ZERO;
                else if (is_digit(b))
                begin
                    add_digit(b);
                    lex_mode = MODE_INT;
                end
                else
                    note_error(ERR_BAD_NUMBER);
            end
            MODE_ZERO, MODE_INT:
            begin
                if (is_digit(b))
                begin
                    if (lex_mode == MODE_ZERO)
                        note_error(ERR_LEAD_ZERO);
                    else
                        add_digit(b);
                end
                else if (b == CH_DOT)
                    lex_mode = MODE_DOT;
                else
                begin
                    note_number();
                    begin_token(b);
                end
            end
            MODE_DOT:
            begin
                if (is_digit(b))
                begin
                    lex_frac = 1'b1;
                    lex_mode = MODE_FRAC;
                end
                else
                    note_error(ERR_NO_FRAC);
            end
            MODE_FRAC:
            begin
                if (!is_digit(b))
                begin
                    note_number();
                    begin_token(b);
                end
            end
            MODE_STR:
            begin
                if (b == CH_QUOTE)
                begin
                    note_simple(KIND_STR_END, 1'b0, 8'h00);
                    clear_lexer();
                end
                else if (b == CH_BACKSLASH)
                    note_error(ERR_ESCAPE);
                else
                    note_simple(KIND_STR_CHAR, 1'b0, b);
            end
            default:
                begin_token(b);
        endcase

        // Close whatever is open at the end of the text
        if (eoi)
        begin
            case (lex_mode)
                MODE_LIT:
                begin
                    if (lit_sel == LIT_NULL)
                        note_error(ERR_NULL);
                    else
                        note_error(ERR_BOOL);
                end
                MODE_MINUS: note_error(ERR_BAD_NUMBER);
                MODE_ZERO, MODE_INT, MODE_FRAC: note_number();
                MODE_DOT: note_error(ERR_NO_FRAC);
                MODE_STR: note_error(ERR_UNTERMINATED);
                default: ;
            endcase
            clear_lexer();
        end

        for (i = 0; i < step_tokens.size(); i++)
        begin
            r = step_tokens[i];
            r.last = (i == step_tokens.size() - 1);
            expected_tokens.push_back(r);
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    task automatic push_char(logic [7:0] b, logic eoi);
        text_byte_t t;
        t.value = b;
        t.ends_text = eoi;
        text_queue.push_back(t);
        queued_bytes++;
    endtask

    task automatic push_text(string s, logic eoi);
        int i;
        for (i = 0; i < s.len(); i++)
            push_char(s[i], eoi && (i == s.len() - 1));
    endtask

    // Random byte that ends the text now and then
    task automatic push_rand(logic [7:0] b);
        push_char(b, $urandom_range(0, 39) == 0);
    endtask

    task automatic push_digits(int n);
        int i;
        for (i = 0; i < n; i++)
            push_rand(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic random_number();
        string edges[8];
        string s;
        int    i;
        edges = '{"2147483647", "2147483648", "-2147483648", "-2147483649",
                  "99999999999", "-0", "0.0", "-4294967296"};
        if ($urandom_range(0, 9) == 0)
        begin
            s = edges[$urandom_range(0, 7)];
            for (i = 0; i < s.len(); i++)
                push_rand(s[i]);
            return;
        end
        if ($urandom_range(0, 2) == 0)
            push_rand(CH_MINUS);
        case ($urandom_range(0, 9))
            0: push_rand(CH_ZERO);
            1:
            begin
                // leading zero followed by a digit
                push_rand(CH_ZERO);
                push_digits(1);
            end
            2: push_rand(8'($urandom_range(0, 255)));
            default:
            begin
                push_rand(8'h31 + 8'($urandom_range(0, 8)));
                push_digits(($urandom_range(0, 5) == 0) ? $urandom_range(8, 11)
                                                        : $urandom_range(0, 3));
            end
        endcase
        if ($urandom_range(0, 2) == 0)
        begin
            push_rand(CH_DOT);
            if ($urandom_range(0, 7) == 0)
                push_rand(8'($urandom_range(0, 255)));
            else
                push_digits($urandom_range(1, 3));
        end
    endtask

    task automatic random_token();
        string word;
        int    pick;
        int    n;
        int    i;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            case ($urandom_range(0, 2))
                0: word = "null";
                1: word = "true";
                default: word = "false";
            endcase
            // break the literal now and then with a random byte
            if ($urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, word.len() - 1);
                for (i = 0; i < n; i++)
                    push_rand(word[i]);
                push_rand(8'($urandom_range(0, 255)));
            end
            else
                for (i = 0; i < word.len(); i++)
                    push_rand(word[i]);
        end
        else if (pick < 50)
            random_number();
        else if (pick < 75)
        begin
            push_rand(CH_QUOTE);
            n = $urandom_range(0, 8);
            for (i = 0; i < n; i++)
                push_rand(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) != 0)
                push_rand(CH_QUOTE);
        end
        else if (pick < 85)
        begin
            case ($urandom_range(0, 3))
                0: push_rand(CH_SPACE);
                1: push_rand(CH_TAB);
                2: push_rand(CH_CR);
                default: push_rand(CH_LF);
            endcase
            ignored_bytes++;
        end
        else
            push_rand(8'($urandom_range(0, 255)));
    endtask

    task automatic add_random(int n);
        int start;
        start = queued_bytes - ignored_bytes;
        while (queued_bytes - ignored_bytes - start < n)
            random_token();
    endtask

    // Hold the sender until every queued byte is taken and every token is back
    task automatic wait_drained();
        @(negedge clk);
        while (text_queue.size() != 0 || item_valid || expected_tokens.size() != 0)
            @(negedge clk);
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        logic       next_valid;
        text_byte_t t;
        if (!rst_n)
        begin
            item_valid   <= 1'b0;
            in_byte      <= 8'h00;
            end_of_input <= 1'b0;
            burst_left   <= 0;
            gap_left     <= 0;
        end
        else
        begin
            next_valid = item_valid;
            if (item_valid && !item_stall)
            begin
                lex_byte(in_byte, end_of_input);
                next_valid = 1'b0;
            end
            // Advance to the next byte unless a gap is running
            if (!next_valid)
            begin
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
                else if (text_queue.size() != 0)
                begin
                    t = text_queue.pop_front();
                    in_byte      <= t.value;
                    end_of_input <= t.ends_text;
                    next_valid = 1'b1;
                    if (burst_left > 1)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(1, 32);
                        gap_left   <= steady ? 0 : $urandom_range(0, 7);
                    end
                end
            end
            item_valid <= next_valid;
        end
    end

    // ---------------------------------------------------------------- receiver

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall   <= 1'b0;
            stall_window   <= 0;
            stall_pct      <= 0;
            long_hold_left <= 0;
            long_hold_done <= 1'b0;
        end
        else if (!long_hold_done && tokens_seen >= 400)
        begin
            // hold off long enough for the block to fill and stall its input
            long_hold_left <= LONG_HOLD;
            long_hold_done <= 1'b1;
            result_stall   <= 1'b1;
        end
        else if (long_hold_left != 0)
        begin
            long_hold_left <= long_hold_left - 1;
            result_stall   <= 1'b1;
        end
        else
        begin
            if (stall_window == 0)
            begin
                stall_window <= $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0: stall_pct <= 0;
                    1: stall_pct <= 20;
                    2: stall_pct <= 50;
                    default: stall_pct <= 85;
                endcase
            end
            else
                stall_window <= stall_window - 1;
            result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic check_field(string name, logic signed [32:0] want, logic signed [32:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_tokens
        result_t want;
        if (rst_n && result_valid === 1'b1 && !result_stall)
        begin
            tokens_seen++;
            if (expected_tokens.size() == 0)
            begin
                $error("unexpected result: kind %0d with nothing expected", kind);
                error_count++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                check_field("kind", want.kind, kind);
                check_field("bool_value", want.bool_value, bool_value);
                check_field("number_value", want.number_value, number_value);
                check_field("has_fraction", want.has_fraction, has_fraction);
                check_field("string_char", want.string_char, string_char);
                check_field("error_code", want.error_code, error_code);
                check_field("last", want.last, last);
            end
        end
    end

    // Count cycles in which neither side moves a request
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid === 1'b1 && !result_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin : run_test
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        fork
            begin
                @(negedge clk);
                // literals, number endings, string bytes and end-of-text cases
                push_text("true", 1'b0);
                push_text("01", 1'b0);
                push_text("nx", 1'b0);
                push_text("-0.5", 1'b0);
                push_char(CH_QUOTE, 1'b0);
                push_char(8'h00, 1'b0);
                push_char(8'hFF, 1'b0);
                push_char(CH_BACKSLASH, 1'b0);
                push_text("7", 1'b0);
                push_char(8'h00, 1'b0);
                push_char(CH_QUOTE, 1'b0);
                push_char(CH_QUOTE, 1'b0);
                push_text("5.", 1'b1);
                push_text("f", 1'b1);
                push_text("null", 1'b0);
                push_char(CH_QUOTE, 1'b0);
                push_text("a", 1'b1);
                push_text("-", 1'b1);
                wait_drained();

                steady = 1'b0;
                add_random(900);
                wait_drained();

                // stretch with no sender gaps
                steady = 1'b1;
                add_random(300);
                while (text_queue.size() != 0)
                    @(negedge clk);
                steady = 1'b0;
                add_random(550);
                wait_drained();
                repeat (8) @(posedge clk);
            end
            begin
                wait (stuck_cycles >= STUCK_LIMIT);
                timed_out = 1'b1;
            end
        join_any
        if (!timed_out && error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/jst_pkg.sv
rtl/core/jst_lexer.sv
rtl/core/jst_outq.sv
rtl/core/json_scalar_tokenizer.sv
verif/json_scalar_tokenizer_tb.sv
